// File: design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared definitions for the descending radix sorter
// Widths, radix constants, sequencer states and digit helpers.
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int KEY_W       = 32;
	localparam int TAG_W       = 16;
	localparam int DIGIT_W     = 8;
	localparam int RADIX       = 256;
	localparam int MAX_PASSES  = 4;
	localparam int PASS_W      = 2;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CLEAR,
		S_CNT_RD,
		S_CNT_HRD,
		S_CNT_WR,
		S_PRE_RD,
		S_PRE_WR,
		S_SC_RD,
		S_SC_HRD,
		S_SC_WR,
		S_EMIT
	} state_t;

	function automatic logic [DIGIT_W-1:0] slot_of(input logic [KEY_W-1:0] key,
		input logic [PASS_W-1:0] pass);
		logic [KEY_W-1:0] sh;
		sh = key >> {pass, 3'b000};
		return ~sh[DIGIT_W-1:0];
	endfunction

	function automatic logic pass_go(input logic [KEY_W-1:0] max_count,
		input logic [PASS_W-1:0] pass);
		return (max_count >> {pass, 3'b000}) != '0;
	endfunction

endpackage

// File: design/radix_sort_descending.sv
// ----------------------------------------------------------------------------
// radix_sort_descending: stable LSD radix sorter, base 256, largest first
// Loading takes one cycle per request; a request with last set starts the sort.
// Each byte pass runs histogram clear, count, prefix sum and scatter over the
// n stored entries; up to four passes, set by max_count.
// The sorted burst then leaves one result per cycle, n results in all.
// Reset clears the sequencer, fill count and max_count; memories are not cleared.
// ----------------------------------------------------------------------------
module radix_sort_descending #(
	parameter int ENTRIES = rsd_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rsd_pkg::KEY_W-1:0] count,
	input  logic [rsd_pkg::TAG_W-1:0] tag,
	input  logic                      last,
	output logic                      strobe,
	output logic [rsd_pkg::KEY_W-1:0] count_res,
	output logic [rsd_pkg::TAG_W-1:0] tag_res,
	output logic                      last_res,
	input  logic                      cfg_we,
	input  logic [rsd_pkg::KEY_W-1:0] cfg_data
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = rsd_pkg::KEY_W + rsd_pkg::TAG_W;
	localparam int DW = rsd_pkg::DIGIT_W;

	rsd_pkg::state_t state_q, state_d;

	logic [rsd_pkg::KEY_W-1:0]  max_count_q;
	logic [rsd_pkg::PASS_W-1:0] pass_q;
	logic [CW-1:0]              fill_q;
	logic [CW-1:0]              idx_q;
	logic [DW-1:0]              hidx_q;
	logic [CW-1:0]              acc_q;
	logic                       sel_q;
	logic                       strobe_s1;
	logic                       last_s1;

	logic [EW-1:0] bank_rd [2];
	logic [EW-1:0] cur_rd;
	logic [1:0]    bank_we;
	logic [AW-1:0] bank_waddr;
	logic [EW-1:0] bank_wdata;
	logic [CW-1:0] hist_rd;
	logic          hist_we;
	logic [DW-1:0] hist_waddr;
	logic [CW-1:0] hist_wdata;
	logic [DW-1:0] hist_raddr;
	logic [DW-1:0] slot;
	logic [CW-1:0] last_idx;
	logic [CW-1:0] sum;
	logic [CW-1:0] pos;
	logic          store_ok;
	logic          idx_end;
	logic          hidx_end;
	logic          more_pass;

	assign cur_rd    = sel_q ? bank_rd[1] : bank_rd[0];
	assign slot      = rsd_pkg::slot_of(cur_rd[EW-1:rsd_pkg::TAG_W], pass_q);
	assign last_idx  = fill_q - CW'(1);
	assign sum       = acc_q + hist_rd;
	assign pos       = hist_rd - CW'(1);
	assign store_ok  = fill_q < CW'(ENTRIES);
	assign idx_end   = idx_q == last_idx;
	assign hidx_end  = hidx_q == DW'(rsd_pkg::RADIX - 1);
	assign more_pass = (pass_q != rsd_pkg::PASS_W'(rsd_pkg::MAX_PASSES - 1)) &&
		rsd_pkg::pass_go(max_count_q, pass_q + rsd_pkg::PASS_W'(1));

	for (genvar b = 0; b < 2; b++) begin : g_bank
		rsd_ram #(.W(EW), .DEPTH(ENTRIES), .AW(AW)) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_waddr),
			.wdata (bank_wdata),
			.raddr (idx_q[AW-1:0]),
			.rdata (bank_rd[b])
		);
	end

	rsd_ram #(.W(CW), .DEPTH(rsd_pkg::RADIX), .AW(DW)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsd_pkg::S_LOAD: begin
				if (start && last) begin
					state_d = rsd_pkg::pass_go(max_count_q, '0) ?
						rsd_pkg::S_CLEAR : rsd_pkg::S_EMIT;
				end
			end
			rsd_pkg::S_CLEAR: begin
				if (hidx_end) begin
					state_d = rsd_pkg::S_CNT_RD;
				end
			end
			rsd_pkg::S_CNT_RD:  state_d = rsd_pkg::S_CNT_HRD;
			rsd_pkg::S_CNT_HRD: state_d = rsd_pkg::S_CNT_WR;
			rsd_pkg::S_CNT_WR: begin
				state_d = idx_end ? rsd_pkg::S_PRE_RD : rsd_pkg::S_CNT_RD;
			end
			rsd_pkg::S_PRE_RD: state_d = rsd_pkg::S_PRE_WR;
			rsd_pkg::S_PRE_WR: begin
				state_d = hidx_end ? rsd_pkg::S_SC_RD : rsd_pkg::S_PRE_RD;
			end
			rsd_pkg::S_SC_RD:  state_d = rsd_pkg::S_SC_HRD;
			rsd_pkg::S_SC_HRD: state_d = rsd_pkg::S_SC_WR;
			rsd_pkg::S_SC_WR: begin
				if (idx_q != '0) begin
					state_d = rsd_pkg::S_SC_RD;
				end else begin
					state_d = more_pass ? rsd_pkg::S_CLEAR : rsd_pkg::S_EMIT;
				end
			end
			rsd_pkg::S_EMIT: begin
				if (idx_end) begin
					state_d = rsd_pkg::S_LOAD;
				end
			end
			default: state_d = rsd_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		busy       = state_q != rsd_pkg::S_LOAD;
		bank_we    = '0;
		bank_waddr = fill_q[AW-1:0];
		bank_wdata = {count, tag};
		hist_we    = 1'b0;
		hist_waddr = hidx_q;
		hist_wdata = '0;
		hist_raddr = slot;
		unique case (state_q)
			rsd_pkg::S_LOAD: begin
				bank_we[sel_q] = start && store_ok;
			end
			rsd_pkg::S_CLEAR: begin
				hist_we = 1'b1;
			end
			rsd_pkg::S_CNT_WR: begin
				hist_we    = 1'b1;
				hist_waddr = slot;
				hist_wdata = hist_rd + CW'(1);
			end
			rsd_pkg::S_PRE_RD: begin
				hist_raddr = hidx_q;
			end
			rsd_pkg::S_PRE_WR: begin
				hist_raddr = hidx_q;
				hist_we    = 1'b1;
				hist_wdata = sum;
			end
			rsd_pkg::S_SC_WR: begin
				bank_we[~sel_q] = 1'b1;
				bank_waddr      = pos[AW-1:0];
				bank_wdata      = cur_rd;
				hist_we         = 1'b1;
				hist_waddr      = slot;
				hist_wdata      = pos;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= '0;
		end else if (cfg_we) begin
			max_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rsd_pkg::S_LOAD;
			pass_q    <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			hidx_q    <= '0;
			acc_q     <= '0;
			sel_q     <= 1'b0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			strobe_s1 <= state_q == rsd_pkg::S_EMIT;
			last_s1   <= (state_q == rsd_pkg::S_EMIT) && idx_end;
			unique case (state_q)
				rsd_pkg::S_LOAD: begin
					if (start) begin
						if (store_ok) begin
							fill_q <= fill_q + CW'(1);
						end
						idx_q  <= '0;
						hidx_q <= '0;
						pass_q <= '0;
					end
				end
				rsd_pkg::S_CLEAR: begin
					hidx_q <= hidx_q + DW'(1);
					idx_q  <= '0;
				end
				rsd_pkg::S_CNT_WR: begin
					idx_q <= idx_q + CW'(1);
					acc_q <= '0;
				end
				rsd_pkg::S_PRE_WR: begin
					acc_q  <= sum;
					hidx_q <= hidx_q + DW'(1);
					idx_q  <= last_idx;
				end
				rsd_pkg::S_SC_WR: begin
					if (idx_q != '0) begin
						idx_q <= idx_q - CW'(1);
					end else begin
						sel_q  <= ~sel_q;
						pass_q <= pass_q + rsd_pkg::PASS_W'(1);
						hidx_q <= '0;
					end
				end
				rsd_pkg::S_EMIT: begin
					if (idx_end) begin
						idx_q  <= '0;
						fill_q <= '0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign strobe    = strobe_s1;
	assign last_res  = last_s1;
	assign count_res = cur_rd[EW-1:rsd_pkg::TAG_W];
	assign tag_res   = cur_rd[rsd_pkg::TAG_W-1:0];

	// A result appears only in the cycle after an emit read was issued.
	a_strobe_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == rsd_pkg::S_EMIT)
		else $error("result strobe without an emit read");

	a_last_marks_result: assert property (@(posedge clk) disable iff (!arst_n)
		last_res |-> strobe)
		else $error("last_res outside a result");

	// The burst has no gaps until its final result.
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_res |=> strobe)
		else $error("gap inside the result burst");

	// Every scattered entry was counted, so its bucket is never empty.
	a_scatter_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rsd_pkg::S_SC_WR |-> hist_rd != '0)
		else $error("scatter from an empty bucket");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ENTRIES))
		else $error("fill count beyond capacity");

endmodule

// File: design/rsd_ram.sv
// ----------------------------------------------------------------------------
// rsd_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsd_ram #(
	parameter int W     = 48,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
